@@ rtl/cltg_pkg.sv @@
// ----------------------------------------------------------------------------
// cltg_pkg
// Shared constants for the class label timeout gate.
// ----------------------------------------------------------------------------
package cltg_pkg;

  // default sizes
  localparam int TableEntriesDef = 16;
  localparam int LabelBitsDef    = 8;

  // fixed field widths
  localparam int LabelW   = 8;   // class_label / filtered_label
  localparam int TimeW    = 32;  // time counter and timer start
  localparam int TimeoutW = 31;  // timeout_ticks register

  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(100);

  // configuration register indexes
  localparam logic RegTimeout = 1'b0;
  localparam logic RegMode    = 1'b1;

  // input word kinds (tuser)
  localparam logic ActTick  = 1'b0;
  localparam logic ActLabel = 1'b1;

  // mode_select codes
  localparam logic ModeShared = 1'b0;
  localparam logic ModeIndep  = 1'b1;

endpackage

@@ rtl/cltg_ram.sv @@
// ----------------------------------------------------------------------------
// cltg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cltg_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/class_label_timeout_gate.sv @@
// ----------------------------------------------------------------------------
// class_label_timeout_gate
// Gates classifier labels by tick-based timeouts, shared or per label.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): tuser = 0 is a tick word, tuser = 1 a label word
//    whose label sits in tdata. Ticks give no output; each label word gives
//    exactly one output word (m_*): gated label in tdata, table-full flag
//    in tuser.
//  - Timing: ticks are taken while idle. A label word scans the timer table
//    through the single read port of the table RAM, one entry per cycle:
//    entry 0 only in shared mode, all TABLE_ENTRIES entries in independent
//    mode, and a decide step then writes the result register. One word is
//    in flight at a time; the next is taken once the block is back in idle.
//  - The result is held in an output register; ticks are still taken while
//    it waits. A further label word stalls in its final step until the
//    receiver has taken the pending result.
//  - Reset clears the time counter, all entry valid bits and the output.
//    No clearing pass: valid bits are flip-flops, RAM contents are only
//    read behind a valid bit.
//  - Config writes (cfg_we_i) take effect at once and clear all timers;
//    write only while idle.
// ----------------------------------------------------------------------------
module class_label_timeout_gate #(
  parameter int TABLE_ENTRIES = cltg_pkg::TableEntriesDef,
  parameter int LABEL_BITS    = cltg_pkg::LabelBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cltg_pkg::TimeoutW-1:0] cfg_wdata_i,
  // input stream
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [cltg_pkg::LabelW-1:0]   s_tdata_i,   // [7:0] class_label
  input  logic                          s_tuser_i,   // [0] action
  // output stream
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [cltg_pkg::LabelW-1:0]   m_tdata_o,   // [7:0] filtered_label
  output logic                          m_tuser_o    // [0] table_full
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = cltg_pkg::TimeW + LABEL_BITS;   // {start, label}
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

  // state codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [cltg_pkg::TimeoutW-1:0] timeout_q;
  logic                          mode_q;
  logic [cltg_pkg::TimeW-1:0]    time_q;
  logic [TABLE_ENTRIES-1:0]      valid_q, valid_d;
  logic [LABEL_BITS-1:0]         label_q;

  // scan bookkeeping
  logic [IW:0]   cnt_q, cnt_d;
  logic          pvld_q, pvld_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          match_q, match_d;
  logic [IW-1:0] match_idx_q, match_idx_d;
  logic          match_rch_q, match_rch_d;
  logic          free_q, free_d;
  logic [IW-1:0] free_idx_q, free_idx_d;

  // output register
  logic                       out_vld_q, out_vld_d;
  logic [LABEL_BITS-1:0]      out_label_q, out_label_d;
  logic                       out_full_q, out_full_d;

  // RAM
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic                       s_acc;
  logic [IW-1:0]              scan_last;
  logic                       issuing;
  logic [LABEL_BITS-1:0]      ent_label;
  logic [cltg_pkg::TimeW-1:0] ent_start, elapsed;
  logic                       ent_v, ent_rch, ent_hit;
  logic                       label_nz;
  logic                       out_free;

  cltg_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_tready_o = (state_q == S_IDLE);
  assign s_acc      = s_tvalid_i && s_tready_o;

  // shared mode only looks at entry 0
  assign scan_last = (mode_q == cltg_pkg::ModeIndep) ? LastIdx : '0;
  assign issuing   = (state_q == S_SCAN) && (cnt_q <= {1'b0, scan_last});
  assign ram_re    = issuing;
  assign ram_raddr = cnt_q[IW-1:0];

  // entry under test, in the cycle after its read
  assign ent_label = ram_rdata[LABEL_BITS-1:0];
  assign ent_start = ram_rdata[EW-1:LABEL_BITS];
  assign elapsed   = time_q - ent_start;   // modular
  assign ent_rch   = (elapsed >= {1'b0, timeout_q});
  assign ent_v     = valid_q[pidx_q];
  assign label_nz  = (label_q != '0);
  assign ent_hit   = ent_v && label_nz && (ent_label == label_q);

  assign out_free  = !out_vld_q || m_tready_i;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    pvld_d      = 1'b0;
    pidx_d      = pidx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_rch_d = match_rch_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    out_vld_d   = out_vld_q && !m_tready_i;
    out_label_d = out_label_q;
    out_full_d  = out_full_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {time_q, label_q};

    unique case (state_q)
      S_IDLE: begin
        if (s_acc && (s_tuser_i == cltg_pkg::ActLabel)) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
        end
      end

      S_SCAN: begin
        if (issuing) begin
          cnt_d  = cnt_q + 1'b1;
          pvld_d = 1'b1;
          pidx_d = cnt_q[IW-1:0];
        end
        if (pvld_q) begin
          if (mode_q == cltg_pkg::ModeShared) begin
            if (ent_v) begin
              match_d     = 1'b1;
              match_idx_d = pidx_q;
              match_rch_d = ent_rch;
            end
          end else begin
            if (ent_hit) begin
              match_d     = 1'b1;
              match_idx_d = pidx_q;
              match_rch_d = ent_rch;
            end else begin
              // expired or empty: entry ends up free
              if (ent_v && ent_rch) begin
                valid_d[pidx_q] = 1'b0;
              end
              if ((!ent_v || ent_rch) && !free_d) begin
                free_d     = 1'b1;
                free_idx_d = pidx_q;
              end
            end
          end
          if (pidx_q == scan_last) begin
            state_d = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_vld_d   = 1'b1;
          out_full_d  = 1'b0;
          out_label_d = label_q;
          if (mode_q == cltg_pkg::ModeShared) begin
            if (match_q && !match_rch_q) begin
              out_label_d = '0;
            end else if (!label_nz) begin
              valid_d[0]  = 1'b0;
              out_label_d = '0;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              valid_d[0] = 1'b1;
            end
          end else begin
            if (!label_nz) begin
              out_label_d = '0;
            end else if (match_q) begin
              if (!match_rch_q) begin
                out_label_d = '0;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = match_idx_q;
              end
            end else if (free_q) begin
              ram_we              = 1'b1;
              ram_waddr           = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
            end else begin
              out_full_d = 1'b1;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      timeout_q <= cltg_pkg::TimeoutReset;
      mode_q    <= cltg_pkg::ModeShared;
      time_q    <= '0;
      valid_q   <= '0;
      pvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pvld_q    <= pvld_d;
      out_vld_q <= out_vld_d;
      if (s_acc && (s_tuser_i == cltg_pkg::ActTick)) begin
        time_q <= time_q + 1'b1;
      end
      if (cfg_we_i) begin
        // any register write drops all timers
        valid_q <= '0;
        unique case (cfg_idx_i)
          cltg_pkg::RegTimeout: timeout_q <= cfg_wdata_i;
          cltg_pkg::RegMode:    mode_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end else begin
        valid_q <= valid_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      label_q <= LABEL_BITS'(s_tdata_i);
    end
    cnt_q       <= cnt_d;
    pidx_q      <= pidx_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    match_rch_q <= match_rch_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    out_label_q <= out_label_d;
    out_full_q  <= out_full_d;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = cltg_pkg::LabelW'(out_label_q);
  assign m_tuser_o  = out_full_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for class_label_timeout_gate: a scoreboard class keeps
// its own copy of the timer table, predicts the gated label and the
// table-full flag for each label word, and checks every output word in order.
// Stimulus runs a directed opener, then random phases over both modes and
// a range of timeouts, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int TblN    = cltg_pkg::TableEntriesDef;
  localparam int LblW    = cltg_pkg::LabelW;
  localparam int TmoW    = cltg_pkg::TimeoutW;
  localparam int TmW     = cltg_pkg::TimeW;
  localparam int WdLimit = 4000;   // cycles with no word moving on either side
  localparam int Settle  = 24;     // wait after drain, ahead of a register write

  typedef struct packed {
    logic [LblW-1:0] label;
    logic            full;
  } gated_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: timer table copy plus queue of expected output words
  // --------------------------------------------------------------------------
  class gate_scoreboard;
    logic [TmoW-1:0]   timeout = cltg_pkg::TimeoutReset;
    logic              mode    = cltg_pkg::ModeShared;
    logic [TmW-1:0]    now     = '0;
    bit                ent_vld [TblN];
    logic [LblW-1:0]   ent_lbl [TblN];
    logic [TmW-1:0]    ent_t0  [TblN];
    gated_word_t       gated_q [$];
    int errors, n_checked, n_ticks, n_labels, n_pass, n_zero, n_full;

    function int pending();
      return gated_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void clear_timers();
      foreach (ent_vld[i]) ent_vld[i] = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [TmoW-1:0] data);
      if (idx == cltg_pkg::RegTimeout) timeout = data;
      else mode = data[0];
      clear_timers();
    endfunction

    // modular elapsed time against the timeout
    function bit expired(int i);
      logic [TmW-1:0] dt;
      dt = now - ent_t0[i];
      return dt >= TmW'(timeout);
    endfunction

    function void arm(int i, logic [LblW-1:0] lbl);
      ent_vld[i] = 1'b1;
      ent_lbl[i] = lbl;
      ent_t0[i]  = now;
    endfunction

    // shared mode: entry 0 is the one timer
    function void gate_shared(logic [LblW-1:0] lbl, output gated_word_t w);
      w = '{label: '0, full: 1'b0};
      if (ent_vld[0]) begin
        if (!expired(0)) return;
        ent_vld[0] = 1'b0;
      end
      if (lbl == '0) return;
      arm(0, lbl);
      w.label = lbl;
    endfunction

    // independent mode: one timer per label, expired others freed
    function void gate_indep(logic [LblW-1:0] lbl, output gated_word_t w);
      int hit;
      int slot;
      hit  = -1;
      slot = -1;
      w    = '{label: '0, full: 1'b0};
      for (int i = 0; i < TblN; i++) begin
        if (!ent_vld[i]) continue;
        if (lbl != '0 && ent_lbl[i] == lbl) hit = i;
        else if (expired(i)) ent_vld[i] = 1'b0;
      end
      if (lbl == '0) return;
      if (hit >= 0) begin
        if (expired(hit)) begin
          arm(hit, lbl);
          w.label = lbl;
        end
        return;
      end
      for (int i = 0; i < TblN; i++) begin
        if (!ent_vld[i]) begin
          slot = i;
          break;
        end
      end
      w.label = lbl;
      if (slot < 0) w.full = 1'b1;
      else arm(slot, lbl);
    endfunction

    function void note_word(logic act, logic [LblW-1:0] lbl);
      gated_word_t w;
      if (act == cltg_pkg::ActTick) begin
        now++;
        n_ticks++;
        return;
      end
      n_labels++;
      if (mode == cltg_pkg::ModeShared) gate_shared(lbl, w);
      else gate_indep(lbl, w);
      gated_q = {gated_q, w};
    endfunction

    task check_word(logic [LblW-1:0] lbl, logic full);
      gated_word_t w;
      if (gated_q.size() == 0) begin
        report($sformatf("output word %0h/%0b with nothing expected", lbl, full));
        return;
      end
      w = gated_q.pop_front();
      n_checked++;
      if (lbl !== w.label)
        report($sformatf("word %0d filtered_label %0h, want %0h", n_checked, lbl, w.label));
      if (full !== w.full)
        report($sformatf("word %0d table_full %0b, want %0b", n_checked, full, w.full));
      if (w.full) n_full++;
      else if (w.label != '0) n_pass++;
      else n_zero++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [TmoW-1:0]   cfg_wdata_i;
  logic              s_tvalid_i;
  logic              s_tready_o;
  logic [LblW-1:0]   s_tdata_i;    // [7:0] class_label
  logic              s_tuser_i;    // [0] action
  logic              m_tvalid_o;
  logic              m_tready_i;
  logic [LblW-1:0]   m_tdata_o;    // [7:0] filtered_label
  logic              m_tuser_o;    // [0] table_full

  gate_scoreboard sb;
  bit idle_on;      // random gaps / stalls enabled
  int quiet_cyc;    // watchdog count
  int n_settings;

  class_label_timeout_gate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output monitor and watchdog. Sampling at the edge sees pre-edge values on
  // both sides since every driver here and in the DUT uses nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) sb.check_word(m_tdata_o, m_tuser_o);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cyc = 0;
      else quiet_cyc++;
      if (quiet_cyc >= WdLimit) begin
        $display("watchdog: %0d cycles with no word moving", WdLimit);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver: ready high for a random stretch, then (when idling) a stall
  // burst of random length. One assignment per edge at most.
  initial begin
    m_tready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // drop valid and hold off until every expected word is back
  task drain();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // register write, only from idle: drain, then wait Settle before the write
  task write_reg(logic idx, logic [TmoW-1:0] data);
    drain();
    repeat (Settle) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i    <= 1'b0;
  endtask

  // both registers, random order; mode write carries junk in the upper bits
  task configure(logic mode, logic [TmoW-1:0] tmo);
    if ($urandom_range(0, 1)) begin
      write_reg(cltg_pkg::RegTimeout, tmo);
      write_reg(cltg_pkg::RegMode, {30'($urandom), mode});
    end else begin
      write_reg(cltg_pkg::RegMode, {30'($urandom), mode});
      write_reg(cltg_pkg::RegTimeout, tmo);
    end
    n_settings++;
  endtask

  // one input word, with an optional gap burst ahead of it
  task put_word(logic act, logic [LblW-1:0] lbl);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= act;
    s_tdata_i  <= lbl;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_word(act, lbl);
  endtask

  // Random phase: labels drawn from a window of pool_n values starting at
  // base, some null labels, ticks at tick_pct. Small pools revisit active
  // timers; pools wider than the table drive it to full.
  task run_phase(int n, int base, int pool_n, int tick_pct);
    logic [LblW-1:0] lbl;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) == 0) drain();
      if ($urandom_range(0, 99) < tick_pct) begin
        put_word(cltg_pkg::ActTick, LblW'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 9) == 0) lbl = '0;
        else lbl = LblW'(base + $urandom_range(0, pool_n - 1));
        put_word(cltg_pkg::ActLabel, lbl);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb          = new;
    idle_on     = 1'b1;
    quiet_cyc   = 0;
    n_settings  = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= cltg_pkg::RegTimeout;
    cfg_wdata_i <= '0;
    s_tvalid_i  <= 1'b0;
    s_tdata_i   <= '0;
    s_tuser_i   <= cltg_pkg::ActTick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: shared, 100 ticks
    put_word(cltg_pkg::ActLabel, 8'hFF);    // opens the gate
    put_word(cltg_pkg::ActLabel, 8'h00);    // held off

    // shared, short timer: null label, open, hold, expiry clears, reopen
    configure(cltg_pkg::ModeShared, 31'd2);
    put_word(cltg_pkg::ActLabel, 8'h00);
    put_word(cltg_pkg::ActLabel, 8'h80);
    put_word(cltg_pkg::ActLabel, 8'h07);
    put_word(cltg_pkg::ActTick,  8'hA5);
    put_word(cltg_pkg::ActTick,  8'h5A);
    put_word(cltg_pkg::ActLabel, 8'h00);    // expired: clears the timer, null gives 0
    put_word(cltg_pkg::ActLabel, 8'h03);

    // independent, timers never expire: fill the table, active match,
    // null label, then a new label into a full table
    configure(cltg_pkg::ModeIndep, 31'h7FFF_FFFF);
    for (int i = 1; i <= TblN; i++) put_word(cltg_pkg::ActLabel, LblW'(i));
    put_word(cltg_pkg::ActLabel, 8'h01);
    put_word(cltg_pkg::ActLabel, 8'h00);
    put_word(cltg_pkg::ActLabel, 8'hC8);

    // random phases over both modes and the timeout range
    configure(cltg_pkg::ModeShared, 31'd0);
    run_phase(150, 1, 8, 30);
    configure(cltg_pkg::ModeIndep, 31'd0);
    run_phase(150, 1, 24, 30);
    configure(cltg_pkg::ModeShared, 31'($urandom_range(1, 8)));
    run_phase(150, $urandom_range(0, 255), 12, 45);
    configure(cltg_pkg::ModeIndep, 31'($urandom_range(2, 12)));
    run_phase(150, $urandom_range(0, 255), 20, 40);
    configure(cltg_pkg::ModeIndep, 31'h7FFF_FFFF);
    run_phase(150, 0, 256, 20);
    configure(cltg_pkg::ModeShared, 31'($urandom));
    run_phase(150, 0, 256, 30);
    configure(cltg_pkg::ModeIndep, 31'($urandom_range(5, 30)));
    run_phase(150, $urandom_range(0, 255), 40, 50);
    configure(cltg_pkg::ModeShared, 31'd1);
    run_phase(150, 0, 256, 40);

    // closing stretch with no gaps or stalls
    idle_on = 1'b0;
    configure(cltg_pkg::ModeIndep, 31'($urandom_range(1, 6)));
    run_phase(150, $urandom_range(0, 255), 16, 40);
    configure(cltg_pkg::ModeIndep, 31'd3);
    run_phase(150, 0, 256, 35);

    drain();
    repeat (Settle + 16) @(posedge clk_i);

    $display("ran %0d label words and %0d ticks over %0d register settings",
             sb.n_labels, sb.n_ticks, n_settings);
    $display("outputs: %0d passed, %0d suppressed, %0d table full, %0d mismatches",
             sb.n_pass, sb.n_zero, sb.n_full, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
